### sv/llpp_pkg.sv
// Shared constants, types and state encodings of the LL(1) predictive parser.
`default_nettype none
package llpp_pkg;

	localparam int NUM_NONTERMINALS_DEF = 16;
	localparam int NUM_TERMINALS_DEF    = 32;
	localparam int MAX_RHS_DEF          = 8;
	localparam int STACK_DEPTH_DEF      = 64;
	localparam int MAX_EXPANSIONS_DEF   = 32;

	localparam logic [4:0] END_MARK = 5'd31;

	// request kinds
	localparam logic [1:0] REQ_HDR     = 2'd0;
	localparam logic [1:0] REQ_SYM     = 2'd1;
	localparam logic [1:0] REQ_RESTART = 2'd2;
	localparam logic [1:0] REQ_TOKEN   = 2'd3;

	// event kinds
	localparam logic [2:0] EV_EXPAND = 3'd0;
	localparam logic [2:0] EV_MATCH  = 3'd1;
	localparam logic [2:0] EV_ACCEPT = 3'd2;
	localparam logic [2:0] EV_REJECT = 3'd3;
	localparam logic [2:0] EV_DONE   = 3'd4;

	// error codes
	localparam logic [2:0] ERR_NONE     = 3'd0;
	localparam logic [2:0] ERR_NO_ENTRY = 3'd1;
	localparam logic [2:0] ERR_MISMATCH = 3'd2;
	localparam logic [2:0] ERR_OVERFLOW = 3'd3;
	localparam logic [2:0] ERR_EXTRA    = 3'd4;
	localparam logic [2:0] ERR_LIMIT    = 3'd5;
	localparam logic [2:0] ERR_EARLY    = 3'd6;

	typedef enum logic [1:0] {
		PS_IDLE,
		PS_PARSING,
		PS_FINISHED
	} parse_st_t;

	typedef enum logic [3:0] {
		FS_CLEAR,
		FS_IDLE,
		FS_EXEC,
		FS_TOK,
		FS_TOP,
		FS_HDR,
		FS_SYMRD,
		FS_SYMWR,
		FS_EMIT
	} fsm_t;

	typedef struct packed {
		logic hdr_wr;
		logic hdr_rd;
		logic sym_wr;
		logic sym_rd;
	} tbl_ctl_t;

endpackage
`default_nettype wire

### sv/ll1_predictive_parser_unit.sv
// Top level of the table-driven LL(1) predictive parser with its sequencer.
// A table write or restart goes through FS_EXEC and FS_EMIT before its done result is output.
// A token reads the stack top; an expansion then reads the header and pushes each symbol
// with a table read and a stack write; each result leaves through FS_EMIT.
// One item is worked at a time; throughput is bound by the single stack and table ports.
// Reset: control clears at once, then a header clearing pass over all 2**(row+column bits)
// header cells (512 by default) runs with s_axis_tready low.
`default_nettype none
module ll1_predictive_parser_unit #(
	parameter int NUM_NONTERMINALS = llpp_pkg::NUM_NONTERMINALS_DEF,
	parameter int NUM_TERMINALS    = llpp_pkg::NUM_TERMINALS_DEF,
	parameter int MAX_RHS          = llpp_pkg::MAX_RHS_DEF,
	parameter int STACK_DEPTH      = llpp_pkg::STACK_DEPTH_DEF,
	parameter int MAX_EXPANSIONS   = llpp_pkg::MAX_EXPANSIONS_DEF
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         cfg_wr_en,
	input  wire  [3:0]  cfg_wr_data,     // start_symbol
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	// nonterminal[3:0], terminal[8:4], entry_valid[9], rhs_length[13:10],
	// rhs_position[16:14], symbol_is_nonterminal[17], symbol_index[22:18], zero[23]
	input  wire  [23:0] s_axis_tdata,
	input  wire  [1:0]  s_axis_tuser,    // req_type[1:0]
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	// error_code[2:0], expanded_nonterminal[6:3], matched_terminal[11:7],
	// production_length[15:12]
	output logic [15:0] m_axis_tdata,
	output logic [2:0]  m_axis_tuser,    // event_res[2:0]
	output logic        m_axis_tlast
);
	// Cell address is the row and column bits side by side.
	localparam int NTW  = (NUM_NONTERMINALS > 1) ? $clog2(NUM_NONTERMINALS) : 1;
	localparam int TW   = $clog2(NUM_TERMINALS);
	localparam int CAW  = NTW + TW;
	localparam int RW   = (MAX_RHS > 1) ? $clog2(MAX_RHS) : 1;
	localparam int LW   = $clog2(MAX_RHS + 1);
	localparam int SAW  = $clog2(STACK_DEPTH);
	localparam int CNTW = $clog2(STACK_DEPTH + 1);
	localparam int EXW  = $clog2(MAX_EXPANSIONS + 1);
	localparam int SUMW = ((CNTW > LW) ? CNTW : LW) + 1;

	// Held input item.
	logic [1:0] req_q;
	logic [3:0] nt_in_q;
	logic [4:0] tok_q;
	logic       ev_in_q;
	logic [3:0] len_in_q;
	logic [2:0] pos_q;
	logic       isnt_q;
	logic [4:0] sym_q;

	// Parser state.
	logic [3:0]          start_q;
	logic [CNTW-1:0]     cnt_q;
	llpp_pkg::parse_st_t pst_q;
	logic [EXW-1:0]      exp_q;
	logic [4:0]          cur_nt_q;
	logic [CAW-1:0]      cell_q;
	logic [LW-1:0]       idx_q;
	logic [LW-1:0]       plen_q;

	// Pending result, moved into the output register in FS_EMIT.
	logic [2:0] r_ev_q, r_err_q;
	logic [3:0] r_nt_q, r_len_q;
	logic       r_last_q;

	llpp_pkg::fsm_t st_q, st_nxt;

	// Memory side.
	llpp_pkg::tbl_ctl_t tctl;
	logic [CAW-1:0]     hdr_addr;
	logic [LW:0]        hdr_wdata, hdr_rdata;
	logic [CAW+RW-1:0]  sym_addr;
	logic [5:0]         sym_wdata, sym_rdata;
	logic               clr_busy;
	logic               stk_we, stk_re;
	logic [SAW-1:0]     stk_addr;
	logic [5:0]         stk_wdata, stk_rdata;

	// Decisions of the output block, applied by the registers.
	logic                set_res;
	logic [2:0]          n_ev, n_err;
	logic [3:0]          n_nt, n_len;
	logic                n_last;
	logic                cnt_ld;
	logic [CNTW-1:0]     cnt_nxt;
	logic                pst_ld;
	llpp_pkg::parse_st_t pst_nxt;
	logic                exp_inc, node_ld, exp_ld, idx_dec, out_ld;

	logic                emit_ok;
	logic                in_xfer;
	logic                wr_in_range, pos_in_range;
	logic [7:0]          nt_ext, tok_ext, top_nt_ext;
	logic [CAW-1:0]      wr_cell, look_cell;
	logic [LW-1:0]       len_sat, idx_m1, hdr_len;
	logic                hdr_valid;
	logic [SUMW-1:0]     depth_sum;

	assign in_xfer = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (st_q == llpp_pkg::FS_IDLE);
	assign emit_ok = !m_axis_tvalid || m_axis_tready;

	assign nt_ext       = 8'(nt_in_q);
	assign tok_ext      = 8'(tok_q);
	assign top_nt_ext   = 8'(stk_rdata[4:0]);
	assign wr_in_range  = (nt_ext < 8'(NUM_NONTERMINALS)) && (tok_ext < 8'(NUM_TERMINALS));
	assign pos_in_range = 8'(pos_q) < 8'(MAX_RHS);
	assign wr_cell      = {nt_ext[NTW-1:0], tok_ext[TW-1:0]};
	assign look_cell    = {top_nt_ext[NTW-1:0], tok_ext[TW-1:0]};
	// saturate long right sides
	assign len_sat      = (8'(len_in_q) > 8'(MAX_RHS)) ? LW'(MAX_RHS) : LW'(len_in_q);
	assign idx_m1       = idx_q - 1'b1;
	assign hdr_valid    = hdr_rdata[LW];
	assign hdr_len      = hdr_rdata[LW-1:0];
	assign depth_sum    = SUMW'(cnt_q) - SUMW'(1) + SUMW'(hdr_len);

	// Next state.
	always_comb begin
		st_nxt = st_q;
		unique case (st_q)
			llpp_pkg::FS_CLEAR: begin
				if (!clr_busy) st_nxt = llpp_pkg::FS_IDLE;
			end
			llpp_pkg::FS_IDLE: begin
				if (in_xfer) begin
					st_nxt = (s_axis_tuser == llpp_pkg::REQ_TOKEN) ? llpp_pkg::FS_TOK
						: llpp_pkg::FS_EXEC;
				end
			end
			llpp_pkg::FS_EXEC: st_nxt = llpp_pkg::FS_EMIT;
			llpp_pkg::FS_TOK: begin
				if (pst_q != llpp_pkg::PS_PARSING || cnt_q == '0) begin
					st_nxt = llpp_pkg::FS_EMIT;
				end else begin
					st_nxt = llpp_pkg::FS_TOP;
				end
			end
			llpp_pkg::FS_TOP: begin
				if (stk_rdata[5] && top_nt_ext < 8'(NUM_NONTERMINALS)
						&& tok_ext < 8'(NUM_TERMINALS)) begin
					st_nxt = llpp_pkg::FS_HDR;
				end else begin
					st_nxt = llpp_pkg::FS_EMIT;
				end
			end
			llpp_pkg::FS_HDR: begin
				if (!hdr_valid || exp_q >= EXW'(MAX_EXPANSIONS)
						|| depth_sum > SUMW'(STACK_DEPTH)) begin
					st_nxt = llpp_pkg::FS_EMIT;
				end else begin
					st_nxt = llpp_pkg::FS_SYMRD;
				end
			end
			llpp_pkg::FS_SYMRD: begin
				st_nxt = (idx_q == '0) ? llpp_pkg::FS_EMIT : llpp_pkg::FS_SYMWR;
			end
			llpp_pkg::FS_SYMWR: st_nxt = llpp_pkg::FS_SYMRD;
			llpp_pkg::FS_EMIT: begin
				if (emit_ok) begin
					st_nxt = r_last_q ? llpp_pkg::FS_IDLE : llpp_pkg::FS_TOK;
				end
			end
			default: st_nxt = llpp_pkg::FS_CLEAR;
		endcase
	end

	// Outputs of each state: memory strobes and register updates.
	always_comb begin
		tctl      = '0;
		hdr_addr  = wr_cell;
		hdr_wdata = {ev_in_q, len_sat};
		sym_addr  = {wr_cell, pos_q[RW-1:0]};
		sym_wdata = {isnt_q, sym_q};
		stk_we    = 1'b0;
		stk_re    = 1'b0;
		stk_addr  = cnt_q[SAW-1:0];
		stk_wdata = sym_rdata;
		set_res   = 1'b0;
		n_ev      = llpp_pkg::EV_DONE;
		n_err     = llpp_pkg::ERR_NONE;
		n_nt      = '0;
		n_len     = '0;
		n_last    = 1'b1;
		cnt_ld    = 1'b0;
		cnt_nxt   = cnt_q;
		pst_ld    = 1'b0;
		pst_nxt   = pst_q;
		exp_inc   = 1'b0;
		node_ld   = 1'b0;
		exp_ld    = 1'b0;
		idx_dec   = 1'b0;
		out_ld    = 1'b0;
		unique case (st_q)
			llpp_pkg::FS_CLEAR: ;
			llpp_pkg::FS_IDLE: begin
				exp_ld = in_xfer;
			end
			llpp_pkg::FS_EXEC: begin
				set_res = 1'b1;
				unique case (req_q)
					llpp_pkg::REQ_HDR: tctl.hdr_wr = wr_in_range;
					llpp_pkg::REQ_SYM: tctl.sym_wr = wr_in_range && pos_in_range;
					llpp_pkg::REQ_RESTART, llpp_pkg::REQ_TOKEN: begin
						// push the start symbol onto an empty stack
						stk_we    = 1'b1;
						stk_addr  = '0;
						stk_wdata = {1'b1, 1'b0, start_q};
						cnt_ld    = 1'b1;
						cnt_nxt   = CNTW'(1);
						pst_ld    = 1'b1;
						pst_nxt   = llpp_pkg::PS_PARSING;
					end
					default: ;
				endcase
			end
			llpp_pkg::FS_TOK: begin
				if (pst_q != llpp_pkg::PS_PARSING) begin
					set_res = 1'b1;
					n_ev    = llpp_pkg::EV_REJECT;
					n_err   = llpp_pkg::ERR_EXTRA;
				end else if (cnt_q == '0) begin
					set_res = 1'b1;
					pst_ld  = 1'b1;
					pst_nxt = llpp_pkg::PS_FINISHED;
					if (tok_q == llpp_pkg::END_MARK) begin
						n_ev = llpp_pkg::EV_ACCEPT;
					end else begin
						n_ev  = llpp_pkg::EV_REJECT;
						n_err = llpp_pkg::ERR_EXTRA;
					end
				end else begin
					stk_re   = 1'b1;
					stk_addr = SAW'(cnt_q - 1'b1);
				end
			end
			llpp_pkg::FS_TOP: begin
				if (stk_rdata[5]) begin
					if (top_nt_ext < 8'(NUM_NONTERMINALS) && tok_ext < 8'(NUM_TERMINALS)) begin
						tctl.hdr_rd = 1'b1;
						hdr_addr    = look_cell;
						node_ld     = 1'b1;
					end else begin
						set_res = 1'b1;
						n_ev    = llpp_pkg::EV_REJECT;
						n_err   = llpp_pkg::ERR_NO_ENTRY;
						n_nt    = stk_rdata[3:0];
						pst_ld  = 1'b1;
						pst_nxt = llpp_pkg::PS_FINISHED;
					end
				end else begin
					set_res = 1'b1;
					if (tok_q == llpp_pkg::END_MARK) begin
						n_ev    = llpp_pkg::EV_REJECT;
						n_err   = llpp_pkg::ERR_EARLY;
						pst_ld  = 1'b1;
						pst_nxt = llpp_pkg::PS_FINISHED;
					end else if (stk_rdata[4:0] != tok_q) begin
						n_ev    = llpp_pkg::EV_REJECT;
						n_err   = llpp_pkg::ERR_MISMATCH;
						pst_ld  = 1'b1;
						pst_nxt = llpp_pkg::PS_FINISHED;
					end else begin
						n_ev    = llpp_pkg::EV_MATCH;
						cnt_ld  = 1'b1;
						cnt_nxt = cnt_q - 1'b1;
					end
				end
			end
			llpp_pkg::FS_HDR: begin
				n_nt = cur_nt_q[3:0];
				if (!hdr_valid) begin
					set_res = 1'b1;
					n_ev    = llpp_pkg::EV_REJECT;
					n_err   = llpp_pkg::ERR_NO_ENTRY;
					pst_ld  = 1'b1;
					pst_nxt = llpp_pkg::PS_FINISHED;
				end else if (exp_q >= EXW'(MAX_EXPANSIONS)) begin
					set_res = 1'b1;
					n_ev    = llpp_pkg::EV_REJECT;
					n_err   = llpp_pkg::ERR_LIMIT;
					pst_ld  = 1'b1;
					pst_nxt = llpp_pkg::PS_FINISHED;
				end else if (depth_sum > SUMW'(STACK_DEPTH)) begin
					set_res = 1'b1;
					n_ev    = llpp_pkg::EV_REJECT;
					n_err   = llpp_pkg::ERR_OVERFLOW;
					n_len   = 4'(hdr_len);
					pst_ld  = 1'b1;
					pst_nxt = llpp_pkg::PS_FINISHED;
				end else begin
					// pop the nonterminal; pushes follow rightmost first
					cnt_ld  = 1'b1;
					cnt_nxt = cnt_q - 1'b1;
					exp_inc = 1'b1;
				end
			end
			llpp_pkg::FS_SYMRD: begin
				if (idx_q == '0) begin
					set_res = 1'b1;
					n_ev    = llpp_pkg::EV_EXPAND;
					n_nt    = cur_nt_q[3:0];
					n_len   = 4'(plen_q);
					n_last  = 1'b0;
				end else begin
					tctl.sym_rd = 1'b1;
					sym_addr    = {cell_q, idx_m1[RW-1:0]};
					idx_dec     = 1'b1;
				end
			end
			llpp_pkg::FS_SYMWR: begin
				stk_we  = 1'b1;
				cnt_ld  = 1'b1;
				cnt_nxt = cnt_q + 1'b1;
			end
			llpp_pkg::FS_EMIT: begin
				out_ld = emit_ok;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q          <= llpp_pkg::FS_CLEAR;
			start_q       <= '0;
			cnt_q         <= '0;
			pst_q         <= llpp_pkg::PS_IDLE;
			exp_q         <= '0;
			m_axis_tvalid <= 1'b0;
		end else begin
			st_q <= st_nxt;
			if (cfg_wr_en) start_q <= cfg_wr_data;
			if (cnt_ld) cnt_q <= cnt_nxt;
			if (pst_ld) pst_q <= pst_nxt;
			// expansion budget restarts with each accepted input item
			if (exp_ld) begin
				exp_q <= '0;
			end else if (exp_inc) begin
				exp_q <= exp_q + 1'b1;
			end
			if (out_ld) begin
				m_axis_tvalid <= 1'b1;
			end else if (m_axis_tready) begin
				m_axis_tvalid <= 1'b0;
			end
		end
	end

	// Payload registers: input item, working registers, pending and output result.
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			req_q    <= s_axis_tuser;
			nt_in_q  <= s_axis_tdata[3:0];
			tok_q    <= s_axis_tdata[8:4];
			ev_in_q  <= s_axis_tdata[9];
			len_in_q <= s_axis_tdata[13:10];
			pos_q    <= s_axis_tdata[16:14];
			isnt_q   <= s_axis_tdata[17];
			sym_q    <= s_axis_tdata[22:18];
		end
		if (node_ld) begin
			cur_nt_q <= stk_rdata[4:0];
			cell_q   <= look_cell;
		end
		if (exp_inc) begin
			idx_q  <= hdr_len;
			plen_q <= hdr_len;
		end else if (idx_dec) begin
			idx_q <= idx_m1;
		end
		if (set_res) begin
			r_ev_q   <= n_ev;
			r_err_q  <= n_err;
			r_nt_q   <= n_nt;
			r_len_q  <= n_len;
			r_last_q <= n_last;
		end
		if (out_ld) begin
			m_axis_tuser <= r_ev_q;
			m_axis_tlast <= r_last_q;
			m_axis_tdata <= {r_len_q,
				(r_ev_q == llpp_pkg::EV_DONE) ? 5'd0 : tok_q, r_nt_q, r_err_q};
		end
	end

	llpp_tables #(
		.CAW(CAW),
		.RW (RW),
		.LW (LW)
	) u_tables (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (tctl),
		.hdr_addr (hdr_addr),
		.hdr_wdata(hdr_wdata),
		.hdr_rdata(hdr_rdata),
		.sym_addr (sym_addr),
		.sym_wdata(sym_wdata),
		.sym_rdata(sym_rdata),
		.clr_busy (clr_busy)
	);

	llpp_stack #(
		.SAW(SAW)
	) u_stack (
		.clk  (clk),
		.we   (stk_we),
		.re   (stk_re),
		.addr (stk_addr),
		.wdata(stk_wdata),
		.rdata(stk_rdata)
	);

endmodule
`default_nettype wire

### sv/llpp_tables.sv
// Parse table memories: production headers (cleared after reset) and right-side symbols.
`default_nettype none
module llpp_tables #(
	parameter int CAW = 9,
	parameter int RW  = 3,
	parameter int LW  = 4
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  llpp_pkg::tbl_ctl_t    ctl,
	input  wire  [CAW-1:0]        hdr_addr,
	input  wire  [LW:0]           hdr_wdata,
	output logic [LW:0]           hdr_rdata,
	input  wire  [CAW+RW-1:0]     sym_addr,
	input  wire  [5:0]            sym_wdata,
	output logic [5:0]            sym_rdata,
	output logic                  clr_busy
);
	localparam int HDEPTH = 1 << CAW;
	localparam int SDEPTH = 1 << (CAW + RW);

	logic [LW:0]  hdr_mem [HDEPTH];
	logic [5:0]   sym_mem [SDEPTH];
	logic [CAW:0] clr_q;

	assign clr_busy = !clr_q[CAW];

	// sweep every header cell to invalid after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (!clr_q[CAW]) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!clr_q[CAW]) begin
			hdr_mem[clr_q[CAW-1:0]] <= '0;
		end else if (ctl.hdr_wr) begin
			hdr_mem[hdr_addr] <= hdr_wdata;
		end
		if (ctl.hdr_rd) begin
			hdr_rdata <= hdr_mem[hdr_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.sym_wr) begin
			sym_mem[sym_addr] <= sym_wdata;
		end
		if (ctl.sym_rd) begin
			sym_rdata <= sym_mem[sym_addr];
		end
	end

endmodule
`default_nettype wire

### sv/llpp_stack.sv
// Parse stack memory, one port, registered read.
`default_nettype none
module llpp_stack #(
	parameter int SAW = 6
) (
	input  wire              clk,
	input  wire              we,
	input  wire              re,
	input  wire  [SAW-1:0]   addr,
	input  wire  [5:0]       wdata,
	output logic [5:0]       rdata
);
	logic [5:0] mem [1 << SAW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule
`default_nettype wire

### sv/llpp_checker.sv
// Port-level checks of the parser unit, bound to the top level.
`default_nettype none
module llpp_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        m_axis_tvalid,
	input wire        m_axis_tready,
	input wire [15:0] m_axis_tdata,
	input wire [2:0]  m_axis_tuser,
	input wire        m_axis_tlast
);
	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tuser) && $stable(m_axis_tlast))
		else $error("result changed while stalled");

	a_reject_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == llpp_pkg::EV_REJECT |->
			m_axis_tdata[2:0] != llpp_pkg::ERR_NONE && m_axis_tlast)
		else $error("reject without error code or not final");

	a_no_err: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser != llpp_pkg::EV_REJECT |->
			m_axis_tdata[2:0] == llpp_pkg::ERR_NONE)
		else $error("error code on a non-reject event");

	a_expand_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == llpp_pkg::EV_EXPAND |-> !m_axis_tlast)
		else $error("expand marked final");

	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser == llpp_pkg::EV_DONE
			|| m_axis_tuser == llpp_pkg::EV_ACCEPT || m_axis_tuser == llpp_pkg::EV_MATCH)
			|-> m_axis_tlast)
		else $error("closing event not final");

endmodule

bind ll1_predictive_parser_unit llpp_checker u_llpp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata),
	.m_axis_tuser (m_axis_tuser),
	.m_axis_tlast (m_axis_tlast)
);
`default_nettype wire
